[hw/rtl/abp_pkg.sv]
// shared codes and types for the arena bump allocator
`timescale 1ns / 1ps
package abp_pkg;

   localparam logic [2:0] ACT_ALLOC   = 3'd0;
   localparam logic [2:0] ACT_RESIZE  = 3'd1;
   localparam logic [2:0] ACT_RELEASE = 3'd2;
   localparam logic [2:0] ACT_POP     = 3'd3;
   localparam logic [2:0] ACT_CLEAR   = 3'd4;

   localparam logic [2:0] STS_OK        = 3'd0;
   localparam logic [2:0] STS_NO_MEMORY = 3'd1;
   localparam logic [2:0] STS_OUT_RANGE = 3'd2;
   localparam logic [2:0] STS_NO_POP    = 3'd3;
   localparam logic [2:0] STS_LIST_FULL = 3'd4;

   localparam logic [31:0] ARENA_RESET = 32'd65536;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      CM_NONE,
      CM_TAKE,
      CM_WRITE,
      CM_CLEAR
   } commit_kind_type;

endpackage

[hw/rtl/abp_cell.sv]
// one free-list entry with its stage of the search chain
`timescale 1ns / 1ps
module abp_cell #(
   parameter int OB    = 32,
   parameter int IW    = 4,
   parameter int INDEX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [OB-1:0] blk,
   input  logic [OB-1:0] size,
   input  logic [3*IW+OB+2:0] probe_in,
   output logic [3*IW+OB+2:0] probe_out,
   input  logic [IW+2*OB+1:0] commit
);
   import abp_pkg::*;

   typedef struct packed {
      logic          pick_found;
      logic [OB-1:0] pick_start;
      logic [IW-1:0] pick_idx;
      logic          hit_found;
      logic [IW-1:0] hit_idx;
      logic          slot_found;
      logic [IW-1:0] slot_idx;
   } probe_type;

   typedef struct packed {
      commit_kind_type kind;
      logic [IW-1:0]   idx;
      logic [OB-1:0]   start;
      logic [OB-1:0]   length;
   } commit_type;

   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

   logic          valid_ff;
   logic          valid_in;
   logic [OB-1:0] start_ff;
   logic [OB-1:0] start_in;
   logic [OB-1:0] length_ff;
   logic [OB-1:0] length_in;
   probe_type     probe_ff;
   probe_type     probe_in_w;
   probe_type     probe_nx;
   commit_type    cm;
   logic          fits;

   assign probe_in_w = probe_in;
   assign cm         = commit;
   assign probe_out  = probe_ff;

   // pass the best candidate so far along, replacing it with ours when ours fits and starts lower
   always_comb begin
      probe_nx = probe_in_w;
      fits = valid_ff && (length_ff >= size);
      if (fits && (!probe_in_w.pick_found || start_ff < probe_in_w.pick_start)) begin
         probe_nx.pick_found = 1'b1;
         probe_nx.pick_start = start_ff;
         probe_nx.pick_idx   = MY_IDX;
      end
      if (!probe_in_w.hit_found && valid_ff && start_ff == blk) begin
         probe_nx.hit_found = 1'b1;
         probe_nx.hit_idx   = MY_IDX;
      end
      if (!probe_in_w.slot_found && !valid_ff) begin
         probe_nx.slot_found = 1'b1;
         probe_nx.slot_idx   = MY_IDX;
      end
   end

   always_comb begin
      valid_in  = valid_ff;
      start_in  = start_ff;
      length_in = length_ff;
      case (cm.kind)
         CM_CLEAR: begin
            valid_in = 1'b0;
         end
         CM_TAKE: begin
            if (cm.idx == MY_IDX) valid_in = 1'b0;
         end
         CM_WRITE: begin
            if (cm.idx == MY_IDX) begin
               valid_in  = 1'b1;
               start_in  = cm.start;
               length_in = cm.length;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      start_ff  <= start_in;
      length_ff <= length_in;
      probe_ff  <= probe_nx;
   end

endmodule

[hw/rtl/arena_bump_allocator.sv]
// top level of the arena bump allocator with its free list
// usage:
// - csr channel: one word per write sets the arena size in bytes; taken only
//   while the block is idle (csr_ready high), reset value 65536
// - req channel: a word carries action, block_offset, request_bytes, old_bytes;
//   taken when req_valid is high and req_stall low
// - rsp channel: one word per request with result_offset, status, copy_bytes
//   and from_free_list; taken when rsp_valid is high and rsp_stall low
// timing:
// - the free list is a row of FREE_ENTRIES cells; a search probe steps one cell
//   per cycle, so alloc, resize and release hold the block through accept, a
//   search across all FREE_ENTRIES cells and finish; pop, clear and unused
//   codes skip the search and go from accept straight to finish
// - one request is in flight at a time; the next is taken while the previous
//   result still waits in the output register
// - if the receiver stalls and the output register is still full, the finish
//   cycle waits, holding the block, until that word is taken
// reset: top and latest offsets go to zero, all free-list entries invalid,
//   no result pending, arena size back to 65536
`timescale 1ns / 1ps
module arena_bump_allocator #(
   parameter int FREE_ENTRIES = 16,
   parameter int OFFSET_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [31:0] req_block_offset,
   input  logic [31:0] req_request_bytes,
   input  logic [31:0] req_old_bytes,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_offset,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_copy_bytes,
   output logic        rsp_from_free_list
);
   import abp_pkg::*;

   localparam int OB = OFFSET_BITS;
   localparam int N  = FREE_ENTRIES;
   localparam int IW = (N > 1) ? $clog2(N) : 1;
   localparam int CW = (N > 1) ? $clog2(N) : 1;
   localparam int PW = 3 * IW + OB + 3;

   typedef struct packed {
      logic          pick_found;
      logic [OB-1:0] pick_start;
      logic [IW-1:0] pick_idx;
      logic          hit_found;
      logic [IW-1:0] hit_idx;
      logic          slot_found;
      logic [IW-1:0] slot_idx;
   } probe_type;

   typedef struct packed {
      commit_kind_type kind;
      logic [IW-1:0]   idx;
      logic [OB-1:0]   start;
      logic [OB-1:0]   length;
   } commit_type;

   // control state
   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [31:0]   arena_ff;
   logic [OB-1:0] top_ff, top_in;
   logic [OB-1:0] latest_ff, latest_in;
   logic          rsp_valid_ff;

   // latched request
   logic [2:0]    act_ff;
   logic [OB-1:0] blk_ff;
   logic [OB-1:0] req_ff;
   logic [OB-1:0] old_ff;

   // result register
   logic [31:0]   res_offset_ff;
   logic [2:0]    res_status_ff;
   logic [31:0]   res_copy_ff;
   logic          res_from_ff;

   // finish-cycle results
   logic [OB-1:0] where_c;
   logic [2:0]    status_c;
   logic [OB-1:0] copy_c;
   logic          from_c;
   commit_type    commit_c;

   logic [PW-1:0] chain_w [0:N];
   probe_type     probe_end;
   probe_type     probe_empty;

   logic          req_fire;
   logic          fin_fire;
   logic [OB:0]   bump_sum;
   logic [OB:0]   grow_sum;
   logic          bump_fail;
   logic          grow_fail;

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign fin_fire  = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // row of free-list cells, probe enters empty at cell zero
   always_comb begin
      probe_empty = '0;
   end
   assign chain_w[0] = probe_empty;

   for (genvar g = 0; g < N; g++) begin : g_cell
      abp_cell #(
         .OB    (OB),
         .IW    (IW),
         .INDEX (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .blk       (blk_ff),
         .size      (req_ff),
         .probe_in  (chain_w[g]),
         .probe_out (chain_w[g+1]),
         .commit    (commit_c)
      );
   end

   assign probe_end = chain_w[N];

   // bump and in-place grow carry an extra bit; an overflow or a sum past the arena size fails
   assign bump_sum  = {1'b0, top_ff} + {1'b0, req_ff};
   assign grow_sum  = {1'b0, latest_ff} + {1'b0, req_ff};
   assign bump_fail = bump_sum[OB] || (65'(bump_sum[OB-1:0]) > 65'(arena_ff));
   assign grow_fail = grow_sum[OB] || (65'(grow_sum[OB-1:0]) > 65'(arena_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_fire) begin
               if (req_action inside {ACT_ALLOC, ACT_RESIZE, ACT_RELEASE}) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(N - 1)) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (fin_fire) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // finish-cycle datapath: result word, offset updates and list commit
   always_comb begin
      where_c   = '0;
      status_c  = STS_OK;
      copy_c    = '0;
      from_c    = 1'b0;
      top_in    = top_ff;
      latest_in = latest_ff;
      commit_c  = '{kind: CM_NONE, idx: '0, start: blk_ff, length: req_ff};
      case (act_ff)
         ACT_ALLOC, ACT_RESIZE: begin
            if (act_ff == ACT_RESIZE && blk_ff >= top_ff) begin
               status_c = STS_OUT_RANGE;
            end else if (act_ff == ACT_RESIZE && blk_ff == latest_ff) begin
               // latest block grows or shrinks where it is
               if (grow_fail) begin
                  status_c = STS_NO_MEMORY;
               end else begin
                  top_in  = grow_sum[OB-1:0];
                  where_c = blk_ff;
               end
            end else if (probe_end.pick_found) begin
               where_c      = probe_end.pick_start;
               from_c       = 1'b1;
               commit_c.kind = CM_TAKE;
               commit_c.idx  = probe_end.pick_idx;
            end else if (bump_fail) begin
               status_c = STS_NO_MEMORY;
            end else begin
               latest_in = top_ff;
               top_in    = bump_sum[OB-1:0];
               where_c   = top_ff;
            end
            // relocating resize reports how much to move
            if (act_ff == ACT_RESIZE && blk_ff < top_ff && blk_ff != latest_ff
                && (probe_end.pick_found || !bump_fail)) begin
               copy_c = (old_ff < req_ff) ? old_ff : req_ff;
            end
         end
         ACT_RELEASE: begin
            if (probe_end.hit_found) begin
               commit_c.kind = CM_WRITE;
               commit_c.idx  = probe_end.hit_idx;
            end else if (probe_end.slot_found) begin
               commit_c.kind = CM_WRITE;
               commit_c.idx  = probe_end.slot_idx;
            end else begin
               status_c = STS_LIST_FULL;
            end
         end
         ACT_POP: begin
            if (top_ff == latest_ff) status_c = STS_NO_POP;
            else top_in = latest_ff;
         end
         ACT_CLEAR: begin
            top_in        = '0;
            latest_in     = '0;
            commit_c.kind = CM_CLEAR;
         end
         default: begin
         end
      endcase
      // nothing changes until the result word can be loaded
      if (!fin_fire) begin
         top_in        = top_ff;
         latest_in     = latest_ff;
         commit_c.kind = CM_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         arena_ff     <= ARENA_RESET;
         top_ff       <= '0;
         latest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         top_ff    <= top_in;
         latest_ff <= latest_in;
         if (csr_valid && csr_ready) arena_ff <= csr_wdata;
         if (fin_fire) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff <= req_action;
         blk_ff <= OB'(req_block_offset);
         req_ff <= OB'(req_request_bytes);
         old_ff <= OB'(req_old_bytes);
      end
      if (fin_fire) begin
         res_offset_ff <= 32'(where_c);
         res_status_ff <= status_c;
         res_copy_ff   <= 32'(copy_c);
         res_from_ff   <= from_c;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_offset  = res_offset_ff;
   assign rsp_status         = res_status_ff;
   assign rsp_copy_bytes     = res_copy_ff;
   assign rsp_from_free_list = res_from_ff;

   // list updates happen only in the finish cycle
   assert property (@(posedge clock) disable iff (reset)
      commit_c.kind != CM_NONE |-> state_ff == ST_FINISH)
      else $error("free-list commit outside finish");

   // an accepted word always starts work
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("accepted request dropped");

   // a block from the list is always a success
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_from_ff |-> res_status_ff == STS_OK)
      else $error("free-list block with failure status");

endmodule
